// ===== hdl/ps2_keyboard_controller_host_port_defines.svh =====
// Assertion helpers for the keyboard controller RTL.
`ifndef PS2_KEYBOARD_CONTROLLER_HOST_PORT_DEFINES_SVH
`define PS2_KEYBOARD_CONTROLLER_HOST_PORT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PS2KC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PS2KC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ps2kc_pkg.sv =====
`default_nettype none

package ps2kc_pkg;

  // Bytes in one mouse movement packet (3 or 4).
  localparam int MOUSE_PACKET_BYTES = 3;

  // Port access kinds
  typedef enum logic [1:0] {
    OP_CMD_WR    = 2'd0,
    OP_DATA_WR   = 2'd1,
    OP_STATUS_RD = 2'd2,
    OP_DATA_RD   = 2'd3
  } opcode_t;

  // Forward targets
  localparam logic [1:0] FWD_NONE   = 2'd0;
  localparam logic [1:0] FWD_KBD    = 2'd1;
  localparam logic [1:0] FWD_MOUSE  = 2'd2;
  localparam logic [1:0] FWD_INJECT = 2'd3;

  // Controller commands
  localparam logic [7:0] CMD_READ_CB     = 8'h20;
  localparam logic [7:0] CMD_WRITE_CB    = 8'h60;
  localparam logic [7:0] CMD_MOUSE_DIS   = 8'hA7;
  localparam logic [7:0] CMD_MOUSE_EN    = 8'hA8;
  localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
  localparam logic [7:0] CMD_IF_TEST     = 8'hAB;
  localparam logic [7:0] CMD_KBD_DIS     = 8'hAD;
  localparam logic [7:0] CMD_KBD_EN      = 8'hAE;
  localparam logic [7:0] CMD_READ_OPORT  = 8'hD0;
  localparam logic [7:0] CMD_WRITE_OPORT = 8'hD1;
  localparam logic [7:0] CMD_WRITE_KBUF  = 8'hD2;
  localparam logic [7:0] CMD_WRITE_ABUF  = 8'hD3;
  localparam logic [7:0] CMD_WRITE_AUX   = 8'hD4;
  localparam logic [7:0] CMD_RESET       = 8'hFE;

  // Fixed replies
  localparam logic [7:0] SELF_TEST_PASS = 8'h55;
  localparam logic [7:0] IF_TEST_PASS   = 8'h00;

  // Status byte bits
  localparam int ST_OBF = 0;
  localparam int ST_CMD = 3;
  localparam int ST_AUX = 5;

  // Command byte bits
  localparam int CB_KBD_IRQ   = 0;
  localparam int CB_MOUSE_IRQ = 1;
  localparam int CB_KBD_DIS   = 4;
  localparam int CB_MOUSE_DIS = 5;

  // Reset values
  localparam logic [7:0] STATUS_RESET   = 8'h1C;
  localparam logic [7:0] OUT_PORT_RESET = 8'hDF;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] write_byte;
    logic       kbd_pending;
    logic [7:0] kbd_byte;
    logic       mouse_pending;
    logic [7:0] mouse_byte;
    logic       mouse_is_reply;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq1;
    logic       irq12;
    logic [1:0] fwd_target;
    logic [7:0] fwd_byte;
    logic       pop_kbd;
    logic       pop_mouse;
    logic       system_reset;
    logic       kbd_enabled;
    logic       mouse_enabled;
  } result_t;

  typedef struct packed {
    logic [7:0] status_reg;
    logic [7:0] command_byte;
    logic [7:0] pending_cmd;
    logic       awaiting_data;
    logic [7:0] out_buffer;
    logic [7:0] out_port;
    logic       mouse_irq_on;
    logic       kbd_irq_on;
    logic [1:0] packet_count;
    logic       kbd_on;
    logic       mouse_on;
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== hdl/ps2kc_decode.sv =====
`default_nettype none

// One port access: decodes the item against the current controller state and
// produces the next state and the transaction result.
module ps2kc_decode (
  input  wire ps2kc_pkg::item_t       item,
  input  wire ps2kc_pkg::ctrl_state_t st,
  output ps2kc_pkg::ctrl_state_t      st_next,
  output ps2kc_pkg::result_t          res_next
);

  ps2kc_pkg::ctrl_state_t s;
  ps2kc_pkg::result_t     r;
  logic                   reply_en;
  logic [7:0]             reply_val;
  logic                   svc_en;
  logic                   mouse_first;
  logic                   take_kbd;
  logic                   take_mouse;

  always_comb begin
    s         = st;
    r         = '0;
    reply_en  = 1'b0;
    reply_val = '0;
    svc_en    = 1'b0;

    unique case (item.opcode)
      ps2kc_pkg::OP_CMD_WR: begin
        s.pending_cmd                   = item.write_byte;
        s.status_reg[ps2kc_pkg::ST_CMD] = 1'b1;
        s.awaiting_data                 = 1'b0;
        case (item.write_byte) inside
          ps2kc_pkg::CMD_READ_CB: begin
            reply_en  = 1'b1;
            reply_val = st.command_byte;
          end
          ps2kc_pkg::CMD_KBD_DIS: begin
            s.command_byte[ps2kc_pkg::CB_KBD_DIS] = 1'b1;
            s.kbd_on = 1'b0;
          end
          ps2kc_pkg::CMD_KBD_EN: begin
            s.command_byte[ps2kc_pkg::CB_KBD_DIS] = 1'b0;
            s.kbd_on = 1'b1;
          end
          ps2kc_pkg::CMD_MOUSE_DIS: begin
            s.command_byte[ps2kc_pkg::CB_MOUSE_DIS] = 1'b1;
            s.mouse_on = 1'b0;
          end
          ps2kc_pkg::CMD_MOUSE_EN: begin
            s.command_byte[ps2kc_pkg::CB_MOUSE_DIS] = 1'b0;
            s.mouse_on = 1'b1;
          end
          ps2kc_pkg::CMD_READ_OPORT: begin
            reply_en  = 1'b1;
            reply_val = st.out_port;
          end
          ps2kc_pkg::CMD_SELF_TEST: begin
            reply_en  = 1'b1;
            reply_val = ps2kc_pkg::SELF_TEST_PASS;
          end
          ps2kc_pkg::CMD_IF_TEST: begin
            reply_en  = 1'b1;
            reply_val = ps2kc_pkg::IF_TEST_PASS;
          end
          ps2kc_pkg::CMD_RESET: begin
            r.system_reset = 1'b1;
          end
          ps2kc_pkg::CMD_WRITE_AUX, ps2kc_pkg::CMD_WRITE_CB, ps2kc_pkg::CMD_WRITE_ABUF,
          ps2kc_pkg::CMD_WRITE_KBUF, ps2kc_pkg::CMD_WRITE_OPORT: begin
            s.awaiting_data = 1'b1;
          end
          default: begin
          end
        endcase
      end

      ps2kc_pkg::OP_DATA_WR: begin
        if (st.awaiting_data) begin
          s.awaiting_data = 1'b0;
          case (st.pending_cmd)
            ps2kc_pkg::CMD_WRITE_AUX: begin
              r.fwd_target = ps2kc_pkg::FWD_MOUSE;
              r.fwd_byte   = item.write_byte;
              s.status_reg[ps2kc_pkg::ST_AUX] = 1'b1;
              s.status_reg[ps2kc_pkg::ST_OBF] = 1'b1;
            end
            ps2kc_pkg::CMD_WRITE_CB: begin
              s.kbd_irq_on   = item.write_byte[ps2kc_pkg::CB_KBD_IRQ];
              s.mouse_irq_on = item.write_byte[ps2kc_pkg::CB_MOUSE_IRQ];
              s.kbd_on       = ~item.write_byte[ps2kc_pkg::CB_KBD_DIS];
              s.mouse_on     = ~item.write_byte[ps2kc_pkg::CB_MOUSE_DIS];
              s.command_byte = item.write_byte;
            end
            ps2kc_pkg::CMD_WRITE_ABUF: begin
              s.status_reg[ps2kc_pkg::ST_AUX] = 1'b1;
              s.status_reg[ps2kc_pkg::ST_OBF] = 1'b1;
              s.out_buffer = item.write_byte;
            end
            ps2kc_pkg::CMD_WRITE_KBUF: begin
              r.fwd_target = ps2kc_pkg::FWD_INJECT;
              r.fwd_byte   = item.write_byte;
            end
            ps2kc_pkg::CMD_WRITE_OPORT: begin
              s.out_port = item.write_byte;
            end
            default: begin
            end
          endcase
        end else begin
          // plain data write goes to the keyboard
          r.fwd_target = ps2kc_pkg::FWD_KBD;
          r.fwd_byte   = item.write_byte;
        end
        s.pending_cmd = '0;
        s.status_reg[ps2kc_pkg::ST_CMD] = 1'b0;
      end

      ps2kc_pkg::OP_STATUS_RD: begin
        svc_en = 1'b1;
      end

      ps2kc_pkg::OP_DATA_RD: begin
        r.read_byte = st.out_buffer;
        if (st.status_reg[ps2kc_pkg::ST_OBF]) begin
          s.status_reg[ps2kc_pkg::ST_OBF] = 1'b0;
          s.status_reg[ps2kc_pkg::ST_AUX] = 1'b0;
        end
        svc_en = 1'b1;
      end

      default: begin
      end
    endcase

    // Controller reply into the output buffer; a full buffer only pulses the IRQ
    if (reply_en) begin
      if (s.status_reg[ps2kc_pkg::ST_OBF]) begin
        if (s.status_reg[ps2kc_pkg::ST_AUX]) begin
          r.irq12 = s.mouse_irq_on;
        end else begin
          r.irq1 = 1'b1;
        end
      end else begin
        s.out_buffer = reply_val;
        s.status_reg[ps2kc_pkg::ST_OBF] = 1'b1;
        s.status_reg[ps2kc_pkg::ST_AUX] = 1'b0;
        r.irq1 = 1'b1;
      end
    end

    // Device service: mouse first while a packet is part sent
    mouse_first = (s.packet_count != 2'd0) &&
                  (int'(s.packet_count) < ps2kc_pkg::MOUSE_PACKET_BYTES);
    take_kbd    = 1'b0;
    take_mouse  = 1'b0;
    if (svc_en) begin
      if (!mouse_first) begin
        s.packet_count = '0;
      end
      if (!s.status_reg[ps2kc_pkg::ST_OBF]) begin
        if (mouse_first) begin
          take_mouse = item.mouse_pending;
          take_kbd   = item.kbd_pending && !item.mouse_pending;
        end else begin
          take_kbd   = item.kbd_pending;
          take_mouse = item.mouse_pending && !item.kbd_pending;
        end
      end
    end

    if (take_kbd) begin
      s.out_buffer = item.kbd_byte;
      s.status_reg[ps2kc_pkg::ST_OBF] = 1'b1;
      s.status_reg[ps2kc_pkg::ST_AUX] = 1'b0;
      r.irq1    = 1'b1;
      r.pop_kbd = 1'b1;
    end
    if (take_mouse) begin
      s.out_buffer = item.mouse_byte;
      s.status_reg[ps2kc_pkg::ST_OBF] = 1'b1;
      s.status_reg[ps2kc_pkg::ST_AUX] = 1'b1;
      r.pop_mouse = 1'b1;
      if (s.mouse_irq_on) begin
        r.irq12 = 1'b1;
        s.packet_count = item.mouse_is_reply ? 2'd0 : s.packet_count + 2'd1;
      end
    end

    // status read returns the byte after service
    if (item.opcode == ps2kc_pkg::OP_STATUS_RD) begin
      r.read_byte = s.status_reg;
    end

    r.kbd_enabled   = s.kbd_on;
    r.mouse_enabled = s.mouse_on;
  end

  assign st_next  = s;
  assign res_next = r;

endmodule

`default_nettype wire

// ===== hdl/ps2_keyboard_controller_host_port.sv =====
// An accepted access passes through the input register, then is decoded into
// the result register, from which it is shown on the res channel.
// Throughput: one access per cycle unless res_ready stalls; result and input
// registers advance in the same cycle, so a stall holds at most one access.
// Reset (rst, synchronous): status 0x1C, output port 0xDF, both devices and
// both IRQ gates on, all else cleared; no result pending.
`default_nettype none

`include "ps2_keyboard_controller_host_port_defines.svh"

module ps2_keyboard_controller_host_port (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire ps2kc_pkg::item_t     cmd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output ps2kc_pkg::result_t        res
);

  logic                   s1_valid;
  ps2kc_pkg::item_t       s1_item;
  logic                   s1_fire;
  ps2kc_pkg::ctrl_state_t st;
  ps2kc_pkg::ctrl_state_t st_next;
  ps2kc_pkg::result_t     res_next;

  // Stage 1 moves into the result register when that is free or being taken
  assign s1_fire   = s1_valid && (!res_valid || res_ready);
  assign cmd_ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s1_item <= cmd;
    end
  end

  ps2kc_decode u_decode (
    .item     (s1_item),
    .st       (st),
    .st_next  (st_next),
    .res_next (res_next)
  );

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.status_reg    <= ps2kc_pkg::STATUS_RESET;
      st.command_byte  <= '0;
      st.pending_cmd   <= '0;
      st.awaiting_data <= 1'b0;
      st.out_buffer    <= '0;
      st.out_port      <= ps2kc_pkg::OUT_PORT_RESET;
      st.mouse_irq_on  <= 1'b1;
      st.kbd_irq_on    <= 1'b1;
      st.packet_count  <= '0;
      st.kbd_on        <= 1'b1;
      st.mouse_on      <= 1'b1;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= res_next;
    end
  end

  // Checks
  `PS2KC_ASSERT(a_single_pop, res_valid |-> !(res.pop_kbd && res.pop_mouse),
                "both devices popped")
  `PS2KC_ASSERT(a_pop_fills_obf,
                res_valid && (res.pop_kbd || res.pop_mouse) |-> st.status_reg[ps2kc_pkg::ST_OBF],
                "pop without full buffer")
  `PS2KC_ASSERT(a_kbd_pop_irq, res_valid && res.pop_kbd |-> res.irq1,
                "keyboard byte without irq1")
  `PS2KC_ASSERT_ALWAYS(a_fwd_idle_zero,
                       res_valid && (res.fwd_target == ps2kc_pkg::FWD_NONE) |-> (res.fwd_byte == 8'h00),
                       "forward byte without target")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
  import ps2kc_pkg::*;

  localparam int RANDOM_ACCESSES = 1600;
  localparam int TAIL_ACCESSES = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTED = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  item_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  result_t res;

  ps2_keyboard_controller_host_port uut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Port accesses still to be driven and the results they must produce
  item_t pending_accesses[$];
  result_t expected_results[$];
  result_t want;

  int n_errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  logic quiet_tail = 1'b0;

  // Controller image kept by the testbench
  logic [7:0] kc_status;
  logic [7:0] kc_cmd_byte;
  logic [7:0] kc_pending_cmd;
  logic [7:0] kc_out_buf;
  logic [7:0] kc_out_port;
  logic       kc_awaiting;
  logic       kc_mouse_irq_on;
  logic       kc_kbd_irq_on;
  logic       kc_kbd_on;
  logic       kc_mouse_on;
  logic [1:0] kc_pkt_count;
  logic       kc_irq1;
  logic       kc_irq12;

  function automatic void reset_controller();
    kc_status = STATUS_RESET;
    kc_cmd_byte = '0;
    kc_pending_cmd = '0;
    kc_out_buf = '0;
    kc_out_port = OUT_PORT_RESET;
    kc_awaiting = 1'b0;
    kc_mouse_irq_on = 1'b1;
    kc_kbd_irq_on = 1'b1;
    kc_kbd_on = 1'b1;
    kc_mouse_on = 1'b1;
    kc_pkt_count = '0;
  endfunction

  // Put a byte in the output buffer, or only raise the IRQ if it is full
  function automatic void load_output(logic from_mouse, logic reply, logic [7:0] b);
    if (kc_status[ST_OBF]) begin
      if (kc_status[ST_AUX]) begin
        if (kc_mouse_irq_on) kc_irq12 = 1'b1;
      end else begin
        kc_irq1 = 1'b1;
      end
    end else begin
      kc_out_buf = b;
      kc_status[ST_OBF] = 1'b1;
      if (from_mouse) begin
        kc_status[ST_AUX] = 1'b1;
        if (kc_mouse_irq_on) begin
          kc_irq12 = 1'b1;
          if (reply) kc_pkt_count = '0;
          else kc_pkt_count = kc_pkt_count + 2'd1;
        end
      end else begin
        kc_status[ST_AUX] = 1'b0;
        kc_irq1 = 1'b1;
      end
    end
  endfunction

  function automatic void take_kbd(item_t it, inout logic popped);
    if (!kc_status[ST_OBF] && it.kbd_pending) begin
      load_output(1'b0, 1'b1, it.kbd_byte);
      popped = 1'b1;
    end
  endfunction

  function automatic void take_mouse(item_t it, inout logic popped);
    if (!kc_status[ST_OBF] && it.mouse_pending) begin
      load_output(1'b1, it.mouse_is_reply, it.mouse_byte);
      popped = 1'b1;
    end
  endfunction

  // Mouse goes first only while a packet is partly delivered
  function automatic void serve_devices(item_t it, inout logic pk, inout logic pm);
    if (kc_pkt_count > 0 && kc_pkt_count < MOUSE_PACKET_BYTES) begin
      take_mouse(it, pm);
      take_kbd(it, pk);
    end else begin
      kc_pkt_count = '0;
      take_kbd(it, pk);
      take_mouse(it, pm);
    end
  endfunction

  function automatic result_t predict_access(item_t it);
    result_t r;
    logic pk;
    logic pm;
    r = '0;
    pk = 1'b0;
    pm = 1'b0;
    kc_irq1 = 1'b0;
    kc_irq12 = 1'b0;
    case (it.opcode)
      OP_CMD_WR: begin
        kc_pending_cmd = it.write_byte;
        kc_status[ST_CMD] = 1'b1;
        kc_awaiting = 1'b0;
        case (it.write_byte)
          CMD_READ_CB:    load_output(1'b0, 1'b1, kc_cmd_byte);
          CMD_KBD_DIS: begin
            kc_cmd_byte[CB_KBD_DIS] = 1'b1;
            kc_kbd_on = 1'b0;
          end
          CMD_KBD_EN: begin
            kc_cmd_byte[CB_KBD_DIS] = 1'b0;
            kc_kbd_on = 1'b1;
          end
          CMD_MOUSE_DIS: begin
            kc_cmd_byte[CB_MOUSE_DIS] = 1'b1;
            kc_mouse_on = 1'b0;
          end
          CMD_MOUSE_EN: begin
            kc_cmd_byte[CB_MOUSE_DIS] = 1'b0;
            kc_mouse_on = 1'b1;
          end
          CMD_READ_OPORT: load_output(1'b0, 1'b1, kc_out_port);
          CMD_SELF_TEST:  load_output(1'b0, 1'b1, SELF_TEST_PASS);
          CMD_IF_TEST:    load_output(1'b0, 1'b1, IF_TEST_PASS);
          CMD_RESET:      r.system_reset = 1'b1;
          CMD_WRITE_AUX, CMD_WRITE_CB, CMD_WRITE_ABUF, CMD_WRITE_KBUF,
          CMD_WRITE_OPORT: kc_awaiting = 1'b1;
          default: ;
        endcase
      end
      OP_DATA_WR: begin
        if (kc_awaiting) begin
          kc_awaiting = 1'b0;
          case (kc_pending_cmd)
            CMD_WRITE_AUX: begin
              r.fwd_target = FWD_MOUSE;
              r.fwd_byte = it.write_byte;
              kc_status[ST_AUX] = 1'b1;
              kc_status[ST_OBF] = 1'b1;
            end
            CMD_WRITE_CB: begin
              kc_kbd_irq_on = it.write_byte[CB_KBD_IRQ];
              kc_mouse_irq_on = it.write_byte[CB_MOUSE_IRQ];
              kc_kbd_on = !it.write_byte[CB_KBD_DIS];
              kc_mouse_on = !it.write_byte[CB_MOUSE_DIS];
              kc_cmd_byte = it.write_byte;
            end
            CMD_WRITE_ABUF: begin
              kc_status[ST_AUX] = 1'b1;
              kc_status[ST_OBF] = 1'b1;
              kc_out_buf = it.write_byte;
            end
            CMD_WRITE_KBUF: begin
              r.fwd_target = FWD_INJECT;
              r.fwd_byte = it.write_byte;
            end
            CMD_WRITE_OPORT: kc_out_port = it.write_byte;
            default: ;
          endcase
        end else begin
          r.fwd_target = FWD_KBD;
          r.fwd_byte = it.write_byte;
        end
        kc_pending_cmd = '0;
        kc_status[ST_CMD] = 1'b0;
      end
      OP_STATUS_RD: begin
        serve_devices(it, pk, pm);
        r.read_byte = kc_status;
      end
      default: begin
        r.read_byte = kc_out_buf;
        if (kc_status[ST_OBF]) begin
          kc_status[ST_AUX] = 1'b0;
          kc_status[ST_OBF] = 1'b0;
        end
        serve_devices(it, pk, pm);
      end
    endcase
    r.irq1 = kc_irq1;
    r.irq12 = kc_irq12;
    r.pop_kbd = pk;
    r.pop_mouse = pm;
    r.kbd_enabled = kc_kbd_on;
    r.mouse_enabled = kc_mouse_on;
    return r;
  endfunction

  function automatic item_t access(opcode_t op, logic [7:0] wb, logic kp, logic [7:0] kb,
                                   logic mp, logic [7:0] mb, logic mr);
    item_t it;
    it.opcode = op;
    it.write_byte = wb;
    it.kbd_pending = kp;
    it.kbd_byte = kb;
    it.mouse_pending = mp;
    it.mouse_byte = mb;
    it.mouse_is_reply = mr;
    return it;
  endfunction

  // Access with random device traffic alongside; replies are the rarer mouse bytes
  function automatic item_t with_devices(opcode_t op, logic [7:0] wb);
    return access(op, wb, 1'($urandom_range(0, 1)), 8'($urandom),
                  1'($urandom_range(0, 1)), 8'($urandom), $urandom_range(0, 99) < 20);
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] exp_val);
    if (n_errors < MAX_PRINTED)
      $display("result %0d: %s got %02h, expected %02h", n_results, field, got, exp_val);
    n_errors++;
  endtask

  // Driver: presents queued accesses, with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        n_sent++;
        if (n_sent % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 5;
            default: send_idle_pct = 30;
          endcase
        end
      end
      quiet_tail <= (pending_accesses.size() < TAIL_ACCESSES);
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_valid <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 14);
          cmd_valid <= 1'b0;
        end else if (pending_accesses.size() != 0) begin
          cmd <= pending_accesses.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts each accepted access, checks each accepted result
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      reset_controller();
    end else begin
      if (cmd_valid && cmd_ready)
        expected_results.push_back(predict_access(cmd));
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", res.read_byte, 8'h00);
        end else begin
          want = expected_results.pop_front();
          if (res.read_byte !== want.read_byte)
            report_mismatch("read_byte", res.read_byte, want.read_byte);
          if (res.irq1 !== want.irq1)
            report_mismatch("irq1", 8'(res.irq1), 8'(want.irq1));
          if (res.irq12 !== want.irq12)
            report_mismatch("irq12", 8'(res.irq12), 8'(want.irq12));
          if (res.fwd_target !== want.fwd_target)
            report_mismatch("fwd_target", 8'(res.fwd_target), 8'(want.fwd_target));
          if (res.fwd_byte !== want.fwd_byte)
            report_mismatch("fwd_byte", res.fwd_byte, want.fwd_byte);
          if (res.pop_kbd !== want.pop_kbd)
            report_mismatch("pop_kbd", 8'(res.pop_kbd), 8'(want.pop_kbd));
          if (res.pop_mouse !== want.pop_mouse)
            report_mismatch("pop_mouse", 8'(res.pop_mouse), 8'(want.pop_mouse));
          if (res.system_reset !== want.system_reset)
            report_mismatch("system_reset", 8'(res.system_reset), 8'(want.system_reset));
          if (res.kbd_enabled !== want.kbd_enabled)
            report_mismatch("kbd_enabled", 8'(res.kbd_enabled), 8'(want.kbd_enabled));
          if (res.mouse_enabled !== want.mouse_enabled)
            report_mismatch("mouse_enabled", 8'(res.mouse_enabled), 8'(want.mouse_enabled));
        end
        n_results++;
        if (n_results % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 5;
            default: recv_idle_pct = 30;
          endcase
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 14);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int total;
    int pick;
    logic [7:0] c;
    logic [7:0] d;

    // Directed: reset state, every command, full-buffer replies, mouse priority
    pending_accesses.push_back(access(OP_STATUS_RD, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_READ_CB, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_SELF_TEST, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_SELF_TEST, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 1, 8'hFF, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_IF_TEST, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 1, 8'h00, 1, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 0, 8'h00, 1, 8'hFF, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 1, 8'h5A, 1, 8'h01, 0));
    pending_accesses.push_back(access(OP_STATUS_RD, 8'h00, 0, 8'h00, 1, 8'h02, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 1, 8'hAA, 1, 8'hFA, 1));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_KBD_DIS, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_KBD_EN, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_MOUSE_DIS, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_MOUSE_EN, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_READ_OPORT, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_WRITE_OPORT, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_WRITE_KBUF, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'hFF, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_WRITE_ABUF, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'h80, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_IF_TEST, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_WRITE_AUX, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'hF4, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'hED, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_RESET, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_CMD_WR, 8'h00, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'h01, 0, 8'h00, 0, 8'h00, 0));
    // irq gates off and both devices disabled, then a mouse byte with no IRQ12
    pending_accesses.push_back(access(OP_CMD_WR, CMD_WRITE_CB, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'h30, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_RD, 8'h00, 0, 8'h00, 1, 8'h08, 0));
    pending_accesses.push_back(access(OP_CMD_WR, CMD_WRITE_CB, 0, 8'h00, 0, 8'h00, 0));
    pending_accesses.push_back(access(OP_DATA_WR, 8'h03, 0, 8'h00, 0, 8'h00, 0));

    // Random: mostly device traffic and well-formed commands, some noise
    total = pending_accesses.size() + RANDOM_ACCESSES;
    while (pending_accesses.size() < total) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 2) == 0)
          pending_accesses.push_back(with_devices(OP_STATUS_RD, 8'($urandom)));
        else
          pending_accesses.push_back(with_devices(OP_DATA_RD, 8'($urandom)));
      end else if (pick < 90) begin
        case ($urandom_range(0, 14))
          0:  c = CMD_READ_CB;
          1:  c = CMD_WRITE_CB;
          2:  c = CMD_MOUSE_DIS;
          3:  c = CMD_MOUSE_EN;
          4:  c = CMD_SELF_TEST;
          5:  c = CMD_IF_TEST;
          6:  c = CMD_KBD_DIS;
          7:  c = CMD_KBD_EN;
          8:  c = CMD_READ_OPORT;
          9:  c = CMD_WRITE_OPORT;
          10: c = CMD_WRITE_KBUF;
          11: c = CMD_WRITE_ABUF;
          12: c = CMD_WRITE_AUX;
          13: c = CMD_RESET;
          default: c = 8'($urandom);
        endcase
        pending_accesses.push_back(with_devices(OP_CMD_WR, c));
        if (c == CMD_WRITE_CB || c == CMD_WRITE_OPORT || c == CMD_WRITE_KBUF ||
            c == CMD_WRITE_ABUF || c == CMD_WRITE_AUX) begin
          d = 8'($urandom);
          // keep the mouse IRQ gate on most of the time so packets get counted
          if (c == CMD_WRITE_CB && $urandom_range(0, 3) != 0) d[CB_MOUSE_IRQ] = 1'b1;
          // a broken sequence now and then: something other than the data byte
          if ($urandom_range(0, 9) == 0)
            pending_accesses.push_back(with_devices(opcode_t'($urandom_range(0, 3)), d));
          else
            pending_accesses.push_back(with_devices(OP_DATA_WR, d));
        end
      end else begin
        pending_accesses.push_back(with_devices(opcode_t'($urandom_range(0, 3)),
                                                8'($urandom)));
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_accesses.size() != 0 || cmd_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well past the slowest legal run
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
